@@ hdl/hblt_pkg.sv @@
package hblt_pkg;

  localparam int NODE_W       = 16;
  localparam int ELAPSED_W    = 17;
  localparam int CFG_W        = 16;
  localparam int FUNC_W       = 3;
  localparam int STATUS_W     = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int RESULT_LIMIT = 16;
  localparam int EXP_CNT_W    = 5;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Register reset values
  localparam logic [CFG_W-1:0] BEAT_PERIOD_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] MAX_LATENESS_RST = 16'd500;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LATENESS = 1'd1;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_START  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_BEAT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RMALL  = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_TRACKING  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_EXPIRED   = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] node_id;
  } hblt_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] result_status;
    logic [NODE_W-1:0]   result_node;
    logic                last_of_run;
  } hblt_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_DRAIN
  } hblt_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_run;
    logic act;
    logic drain;
    logic clear_all;
  } hblt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              scan_last;
    logic [FUNC_W-1:0] func;
  } hblt_stat_t;

endpackage

@@ hdl/hblt_ram.sv @@
module hblt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/hblt_ctrl.sv @@
module hblt_ctrl import hblt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  hblt_stat_t        stat,
  output hblt_cmd_t         cmd,
  output logic              busy
);

  hblt_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (func)
            FN_TICK, FN_ADD, FN_START, FN_BEAT, FN_REMOVE: state_next = S_SCAN;
            FN_RMALL: cmd.clear_all = 1'b1;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_last) begin
          state_next = (stat.func == FN_TICK) ? S_DRAIN : S_ACT;
        end
      end
      S_ACT: begin
        cmd.act    = 1'b1;
        state_next = S_IDLE;
      end
      S_DRAIN: begin
        cmd.drain  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hdl/hblt_dp.sv @@
module hblt_dp import hblt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hblt_in_t             item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  hblt_cmd_t            cmd,
  output hblt_stat_t           stat,
  output logic                 result_valid,
  output hblt_out_t            result
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int MW = NODE_W + ELAPSED_W;

  logic [CFG_W-1:0]         beat_period, max_lateness;
  logic [FUNC_W-1:0]        func_q;
  logic [NODE_W-1:0]        node_q;
  logic [TABLE_ENTRIES-1:0] valid, track;
  logic [CW-1:0]            rd_cnt;
  logic                     chk_vld;
  logic [IW-1:0]            chk_idx;
  logic                     match_hit, free_hit;
  logic [IW-1:0]            match_idx, free_idx;
  logic [EXP_CNT_W-1:0]     exp_cnt;
  logic                     pend_vld;
  logic [NODE_W-1:0]        pend_node;
  logic                     res_stb_next;
  hblt_out_t                res_next;

  logic                     issue;
  logic [MW-1:0]            rdata;
  logic [NODE_W-1:0]        rd_node;
  logic [ELAPSED_W-1:0]     rd_el, el_inc, limit;
  logic                     is_tick, tick_upd, expire;
  logic                     we;
  logic [IW-1:0]            waddr;
  logic [MW-1:0]            wdata;
  logic [STATUS_W-1:0]      act_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_period  <= BEAT_PERIOD_RST;
      max_lateness <= MAX_LATENESS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BEAT_PERIOD:  beat_period  <= cfg_data;
        REG_MAX_LATENESS: max_lateness <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry store: node id and elapsed count
  hblt_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(rd_cnt[IW-1:0]),
    .rdata(rdata)
  );

  // Scan check logic
  assign issue    = cmd.scan_run && (rd_cnt < CW'(TABLE_ENTRIES));
  assign rd_node  = rdata[MW-1 -: NODE_W];
  assign rd_el    = rdata[ELAPSED_W-1:0];
  assign el_inc   = (rd_el == ELAPSED_MAX) ? rd_el : rd_el + 1'b1;
  assign limit    = {1'b0, beat_period} + {1'b0, max_lateness};
  assign is_tick  = (func_q == FN_TICK);
  assign tick_upd = chk_vld && is_tick && valid[chk_idx];
  assign expire   = tick_upd && track[chk_idx] && (el_inc > limit) &&
                    (exp_cnt < EXP_CNT_W'(RESULT_LIMIT));

  assign stat.scan_last = chk_vld && (chk_idx == IW'(TABLE_ENTRIES - 1));
  assign stat.func      = func_q;

  // Store write and command outcome
  always_comb begin
    we         = tick_upd;
    waddr      = chk_idx;
    wdata      = {rd_node, el_inc};
    act_status = STAT_DONE;
    if (cmd.act) begin
      case (func_q)
        FN_ADD: begin
          if (match_hit) begin
            act_status = STAT_PRESENT;
          end else if (!free_hit) begin
            act_status = STAT_FULL;
          end else begin
            we    = 1'b1;
            waddr = free_idx;
            wdata = {node_q, {ELAPSED_W{1'b0}}};
          end
        end
        FN_START: begin
          if (!match_hit) begin
            act_status = STAT_NOT_FOUND;
          end else if (track[match_idx]) begin
            act_status = STAT_TRACKING;
          end else begin
            we    = 1'b1;
            waddr = match_idx;
            wdata = {node_q, {ELAPSED_W{1'b0}}};
          end
        end
        FN_BEAT: begin
          if (match_hit && track[match_idx]) begin
            we    = 1'b1;
            waddr = match_idx;
            wdata = {node_q, {ELAPSED_W{1'b0}}};
          end else begin
            act_status = STAT_NOT_FOUND;
          end
        end
        FN_REMOVE: begin
          if (!match_hit) begin
            act_status = STAT_NOT_FOUND;
          end
        end
        default: act_status = STAT_DONE;
      endcase
    end
  end

  // Result selection; expiries go out one behind so the last can be marked
  always_comb begin
    res_stb_next = 1'b0;
    res_next     = result;
    if (cmd.clear_all) begin
      res_stb_next = 1'b1;
      res_next     = '{result_status: STAT_DONE, result_node: '0, last_of_run: 1'b1};
    end else if (expire && pend_vld) begin
      res_stb_next = 1'b1;
      res_next     = '{result_status: STAT_EXPIRED, result_node: pend_node,
                       last_of_run: 1'b0};
    end else if (cmd.drain && pend_vld) begin
      res_stb_next = 1'b1;
      res_next     = '{result_status: STAT_EXPIRED, result_node: pend_node,
                       last_of_run: 1'b1};
    end else if (cmd.act) begin
      res_stb_next = 1'b1;
      res_next     = '{result_status: act_status, result_node: node_q,
                       last_of_run: 1'b1};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_stb_next;
    end
    result <= res_next;
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= item.func;
      node_q <= item.node_id;
    end
  end

  // Scan counters and search results
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      chk_vld   <= 1'b0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      exp_cnt   <= '0;
      pend_vld  <= 1'b0;
    end else begin
      chk_vld <= issue;
      if (cmd.load) begin
        rd_cnt    <= '0;
        match_hit <= 1'b0;
        free_hit  <= 1'b0;
        exp_cnt   <= '0;
        pend_vld  <= 1'b0;
      end else begin
        if (issue) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
        if (chk_vld && !is_tick) begin
          if (valid[chk_idx] && (rd_node == node_q) && !match_hit) begin
            match_hit <= 1'b1;
          end
          if (!valid[chk_idx] && !free_hit) begin
            free_hit <= 1'b1;
          end
        end
        if (expire) begin
          exp_cnt  <= exp_cnt + 1'b1;
          pend_vld <= 1'b1;
        end
        if (cmd.drain) begin
          pend_vld <= 1'b0;
        end
      end
    end
  end

  // Scan payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx <= rd_cnt[IW-1:0];
    end
    if (chk_vld && !is_tick) begin
      if (valid[chk_idx] && (rd_node == node_q) && !match_hit) begin
        match_idx <= chk_idx;
      end
      if (!valid[chk_idx] && !free_hit) begin
        free_idx <= chk_idx;
      end
    end
    if (expire) begin
      pend_node <= rd_node;
    end
  end

  // Valid and tracking bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      track <= '0;
    end else if (cmd.clear_all) begin
      valid <= '0;
      track <= '0;
    end else begin
      if (expire) begin
        valid[chk_idx] <= 1'b0;
        track[chk_idx] <= 1'b0;
      end
      if (cmd.act) begin
        case (func_q)
          FN_ADD: begin
            if (!match_hit && free_hit) begin
              valid[free_idx] <= 1'b1;
              track[free_idx] <= 1'b0;
            end
          end
          FN_START: begin
            if (match_hit && !track[match_idx]) begin
              track[match_idx] <= 1'b1;
            end
          end
          FN_REMOVE: begin
            if (match_hit) begin
              valid[match_idx] <= 1'b0;
              track[match_idx] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hdl/node_heartbeat_liveness_table_core.sv @@
// Node heartbeat liveness table.
//
// Command channel: an item (func, node_id) transfers on a rising edge with
// start high and busy low. Tick (once per ms) ages every used entry and removes
// tracked nodes whose count exceeds beat_period + max_lateness; add, start
// tracking, beat and remove look up a node; remove all clears the table.
//
// Every item except remove all and the unused function codes walks the table
// through the entry RAM's single read port, one entry per cycle; busy stays
// high until the walk and its closing step end. Remove all and unused codes
// leave busy low. A result is on result for one cycle with result_valid high;
// a tick gives one result per expired node, in entry order, with last_of_run
// on the final one, and none when nothing expires. Other commands but unused
// codes give one result with last_of_run set. The receiver cannot stall.
//
// Configuration: cfg_valid/cfg_ready with cfg_index (0 beat_period,
// 1 max_lateness) and cfg_data; cfg_ready is always high. Reset sets the
// registers to 1000 and 500 and empties the table; no clearing pass is needed.
module node_heartbeat_liveness_table_core import hblt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  hblt_in_t             item,
  output logic                 result_valid,
  output hblt_out_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  hblt_cmd_t  cmd;
  hblt_stat_t stat;

  assign cfg_ready = 1'b1;

  hblt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .func (item.func),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  hblt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

@@ hdl/hblt_chk.sv @@
module hblt_chk import hblt_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input hblt_in_t  item,
  input logic      result_valid,
  input hblt_out_t result
);

  // A result follows a busy cycle or a remove-all transfer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) || ($past(start) && ($past(item.func) == FN_RMALL))))
    else $error("result without a pending item");

  // Busy only rises after a transfer
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // Unused function codes are dropped without busy and without a result
  a_unused_func: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.func > FN_RMALL)) |=> (!busy && !result_valid))
    else $error("unused function code did work");

  // Remove all answers at once with node zero
  a_rmall: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.func == FN_RMALL)) |=>
      (result_valid && (result.result_node == '0) && result.last_of_run))
    else $error("remove all result missing");

  // Only expiry reports may leave the run open
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.result_status != STAT_EXPIRED)) |-> result.last_of_run)
    else $error("command result not marked last");

endmodule

bind node_heartbeat_liveness_table_core hblt_chk u_chk (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import hblt_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int POOL_N     = 20;
  localparam int PHASES     = 6;
  localparam int PHASE_CMDS = 20;
  localparam int SETTLE     = ENTRIES + 8;
  localparam int CYCLE_CAP  = 300000;

  // func codes the block ignores
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

  typedef enum logic [1:0] {ROW_CMD, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_t;

  // one directed step: a command, or a pair of limit register writes
  typedef struct packed {
    row_kind_t             kind;
    logic [FUNC_W-1:0]     func;
    logic [NODE_W-1:0]     node;
    row_chk_t              chk;
    logic [STATUS_W-1:0]   st;
    logic [NODE_W-1:0]     rnode;
    logic [CFG_W-1:0]      period;
    logic [CFG_W-1:0]      grace;
  } stim_row_t;

  localparam int DIR_N = 27;
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_CMD, FN_REMOVE, 16'h0000, CHK_ONE,   STAT_NOT_FOUND, 16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_BEAT,   16'hFFFF, CHK_ONE,   STAT_NOT_FOUND, 16'hFFFF, 16'd0, 16'd0},
    '{ROW_CMD, FN_START,  16'h1234, CHK_ONE,   STAT_NOT_FOUND, 16'h1234, 16'd0, 16'd0},
    '{ROW_CMD, FN_TICK,   16'h0000, CHK_NONE,  STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_ADD,    16'h0000, CHK_ONE,   STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_ADD,    16'h0000, CHK_ONE,   STAT_PRESENT,   16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_ADD,    16'hFFFF, CHK_ONE,   STAT_DONE,      16'hFFFF, 16'd0, 16'd0},
    '{ROW_CMD, FN_BEAT,   16'hFFFF, CHK_ONE,   STAT_NOT_FOUND, 16'hFFFF, 16'd0, 16'd0},
    '{ROW_CMD, FN_START,  16'hFFFF, CHK_ONE,   STAT_DONE,      16'hFFFF, 16'd0, 16'd0},
    '{ROW_CMD, FN_START,  16'hFFFF, CHK_ONE,   STAT_TRACKING,  16'hFFFF, 16'd0, 16'd0},
    '{ROW_CMD, FN_BEAT,   16'hFFFF, CHK_ONE,   STAT_DONE,      16'hFFFF, 16'd0, 16'd0},
    '{ROW_CMD, FN_SPARE6, 16'hFFFF, CHK_NONE,  STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_SPARE7, 16'h0000, CHK_NONE,  STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_TICK,   16'hFFFF, CHK_NONE,  STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CFG, FN_TICK,   16'h0000, CHK_NONE,  STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_TICK,   16'h0000, CHK_ONE,   STAT_EXPIRED,   16'hFFFF, 16'd0, 16'd0},
    '{ROW_CMD, FN_START,  16'h0000, CHK_ONE,   STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_TICK,   16'h5555, CHK_ONE,   STAT_EXPIRED,   16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_ADD,    16'h5A5A, CHK_ONE,   STAT_DONE,      16'h5A5A, 16'd0, 16'd0},
    '{ROW_CMD, FN_START,  16'h5A5A, CHK_ONE,   STAT_DONE,      16'h5A5A, 16'd0, 16'd0},
    '{ROW_CMD, FN_REMOVE, 16'h5A5A, CHK_ONE,   STAT_DONE,      16'h5A5A, 16'd0, 16'd0},
    '{ROW_CMD, FN_REMOVE, 16'h5A5A, CHK_ONE,   STAT_NOT_FOUND, 16'h5A5A, 16'd0, 16'd0},
    '{ROW_CFG, FN_TICK,   16'h0000, CHK_NONE,  STAT_DONE,      16'h0000, 16'hFFFF, 16'hFFFF},
    '{ROW_CMD, FN_ADD,    16'h8001, CHK_MODEL, STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_START,  16'h8001, CHK_MODEL, STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_TICK,   16'hAAAA, CHK_MODEL, STAT_DONE,      16'h0000, 16'd0, 16'd0},
    '{ROW_CMD, FN_RMALL,  16'h7E81, CHK_ONE,   STAT_DONE,      16'h0000, 16'd0, 16'd0}
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  hblt_in_t             item      = '0;
  logic                 result_valid;
  hblt_out_t            result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  node_heartbeat_liveness_table_core #(.TABLE_ENTRIES(ENTRIES)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // liveness table as the block should hold it
  bit                   ent_used  [ENTRIES];
  bit                   ent_watch [ENTRIES];
  logic [NODE_W-1:0]    ent_id    [ENTRIES];
  logic [ELAPSED_W-1:0] ent_age   [ENTRIES];
  logic [CFG_W-1:0]     period_ms = BEAT_PERIOD_RST;
  logic [CFG_W-1:0]     grace_ms  = MAX_LATENESS_RST;

  hblt_out_t         pending_reports [$];
  hblt_out_t         oldest_report;
  logic [NODE_W-1:0] id_pool [POOL_N];
  int                fails;
  int                sent_cmds;
  int                cycles;
  bit                no_gap_run;

  function automatic hblt_out_t report(logic [STATUS_W-1:0] st, logic [NODE_W-1:0] node,
                                       logic last);
    hblt_out_t r;
    r.result_status = st;
    r.result_node   = node;
    r.last_of_run   = last;
    return r;
  endfunction

  // apply one command to the table and list the reports it should cause
  function automatic void liveness_step(input hblt_in_t it, ref hblt_out_t res[$]);
    int        hit;
    int        free_ix;
    int        n;
    logic [17:0] lim;
    hblt_out_t tail;
    res = {};
    hit = -1;
    free_ix = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && ent_used[i] && ent_id[i] == it.node_id) hit = i;
      if (free_ix < 0 && !ent_used[i]) free_ix = i;
    end
    case (it.func)
      FN_TICK: begin
        lim = {2'b00, period_ms} + {2'b00, grace_ms};
        for (int i = 0; i < ENTRIES; i++)
          if (ent_used[i] && ent_age[i] != ELAPSED_MAX) ent_age[i] = ent_age[i] + 1'b1;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (n < RESULT_LIMIT && ent_used[i] && ent_watch[i] && {1'b0, ent_age[i]} > lim) begin
            ent_used[i]  = 1'b0;
            ent_watch[i] = 1'b0;
            res = {res, report(STAT_EXPIRED, ent_id[i], 1'b0)};
            n++;
          end
        end
        if (res.size() > 0) begin
          tail = res.pop_back();
          tail.last_of_run = 1'b1;
          res = {res, tail};
        end
      end
      FN_ADD: begin
        if (hit >= 0) res = {res, report(STAT_PRESENT, it.node_id, 1'b1)};
        else if (free_ix < 0) res = {res, report(STAT_FULL, it.node_id, 1'b1)};
        else begin
          ent_used[free_ix]  = 1'b1;
          ent_watch[free_ix] = 1'b0;
          ent_id[free_ix]    = it.node_id;
          ent_age[free_ix]   = '0;
          res = {res, report(STAT_DONE, it.node_id, 1'b1)};
        end
      end
      FN_START: begin
        if (hit < 0) res = {res, report(STAT_NOT_FOUND, it.node_id, 1'b1)};
        else if (ent_watch[hit]) res = {res, report(STAT_TRACKING, it.node_id, 1'b1)};
        else begin
          ent_watch[hit] = 1'b1;
          ent_age[hit]   = '0;
          res = {res, report(STAT_DONE, it.node_id, 1'b1)};
        end
      end
      FN_BEAT: begin
        if (hit >= 0 && ent_watch[hit]) begin
          ent_age[hit] = '0;
          res = {res, report(STAT_DONE, it.node_id, 1'b1)};
        end else begin
          res = {res, report(STAT_NOT_FOUND, it.node_id, 1'b1)};
        end
      end
      FN_REMOVE: begin
        if (hit < 0) res = {res, report(STAT_NOT_FOUND, it.node_id, 1'b1)};
        else begin
          ent_used[hit]  = 1'b0;
          ent_watch[hit] = 1'b0;
          res = {res, report(STAT_DONE, it.node_id, 1'b1)};
        end
      end
      FN_RMALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          ent_used[i]  = 1'b0;
          ent_watch[i] = 1'b0;
        end
        res = {res, report(STAT_DONE, '0, 1'b1)};
      end
      default: ;
    endcase
  endfunction

  // present one command, hold it until it transfers, then queue its reports
  task automatic issue_cmd(input hblt_in_t it, input row_chk_t chk, input hblt_out_t typed);
    hblt_out_t got [$];
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    liveness_step(it, got);
    case (chk)
      CHK_MODEL: pending_reports = {pending_reports, got};
      CHK_ONE:   pending_reports = {pending_reports, typed};
      default: ;
    endcase
    if (it.func <= FN_RMALL) sent_cmds++;
  endtask

  // random spacing between commands; now and then wait for every report
  task automatic pace();
    int r;
    int gap;
    if ($urandom_range(0, 24) == 0) no_gap_run = !no_gap_run;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      start <= 1'b0;
      do @(posedge clk); while (pending_reports.size() != 0);
    end else begin
      if (no_gap_run || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // quiet the block before touching the limit registers
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] grace);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BEAT_PERIOD;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    period_ms = period;
    cfg_index <= REG_MAX_LATENESS;
    cfg_data  <= grace;
    do @(posedge clk); while (!cfg_ready);
    grace_ms = grace;
    cfg_valid <= 1'b0;
  endtask

  // mostly nodes in the table or the pool, so lookups hit
  function automatic logic [NODE_W-1:0] pick_node();
    int live [$];
    int r;
    for (int i = 0; i < ENTRIES; i++) if (ent_used[i]) live = {live, i};
    r = $urandom_range(0, 99);
    if (r < 50 && live.size() > 0) return ent_id[live[$urandom_range(0, live.size() - 1)]];
    if (r < 85) return id_pool[$urandom_range(0, POOL_N - 1)];
    return NODE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 34) return FN_TICK;
    if (r < 54) return FN_ADD;
    if (r < 68) return FN_START;
    if (r < 84) return FN_BEAT;
    if (r < 92) return FN_REMOVE;
    if (r < 94) return FN_RMALL;
    if (r < 97) return FN_SPARE6;
    return FN_SPARE7;
  endfunction

  // fill the table past capacity, track every entry, then age it
  task automatic run_fill();
    issue_cmd(hblt_in_t'{func: FN_RMALL, node_id: pick_node()}, CHK_MODEL, '0);
    pace();
    for (int k = 0; k <= ENTRIES; k++) begin
      issue_cmd(hblt_in_t'{func: FN_ADD, node_id: id_pool[k]}, CHK_MODEL, '0);
      pace();
    end
    for (int k = 0; k < ENTRIES; k++) begin
      issue_cmd(hblt_in_t'{func: FN_START, node_id: id_pool[k]}, CHK_MODEL, '0);
      pace();
    end
    issue_cmd(hblt_in_t'{func: FN_TICK, node_id: pick_node()}, CHK_MODEL, '0);
    pace();
  endtask

  // result checker: every strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: status %0d node %h last %0d",
               result.result_status, result.result_node, result.last_of_run);
        fails++;
      end else begin
        oldest_report = pending_reports.pop_front();
        if (result.result_status !== oldest_report.result_status) begin
          $error("result_status: expected %0d, got %0d",
                 oldest_report.result_status, result.result_status);
          fails++;
        end
        if (result.result_node !== oldest_report.result_node) begin
          $error("result_node: expected %h, got %h",
                 oldest_report.result_node, result.result_node);
          fails++;
        end
        if (result.last_of_run !== oldest_report.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d",
                 oldest_report.last_of_run, result.last_of_run);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  int phase_period [PHASES] = '{16'd0, 16'hFFFF, 16'd2, 16'd0, 16'd5, 16'd1};
  int phase_grace  [PHASES] = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd0, 16'd1};

  initial begin
    int target;
    for (int i = 0; i < ENTRIES; i++) begin
      ent_used[i]  = 1'b0;
      ent_watch[i] = 1'b0;
      ent_id[i]    = '0;
      ent_age[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        wait_idle();
        set_limits(DIR_ROWS[r].period, DIR_ROWS[r].grace);
      end else begin
        issue_cmd(hblt_in_t'{func: DIR_ROWS[r].func, node_id: DIR_ROWS[r].node},
                  DIR_ROWS[r].chk,
                  report(DIR_ROWS[r].st, DIR_ROWS[r].rnode, 1'b1));
        pace();
      end
    end

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_N; i++) id_pool[i] = NODE_W'($urandom_range(0, 65535));

    // random phases, one limit setting each
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == PHASES - 1) set_limits(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)));
      else set_limits(CFG_W'(phase_period[p]), CFG_W'(phase_grace[p]));
      if (p % 2 == 0) run_fill();
      target = sent_cmds + PHASE_CMDS;
      while (sent_cmds < target) begin
        issue_cmd(hblt_in_t'{func: pick_func(), node_id: pick_node()}, CHK_MODEL, '0);
        pace();
      end
    end

    // drain and settle
    start <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (SETTLE + 16) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/hblt_pkg.sv
hdl/hblt_ram.sv
hdl/hblt_ctrl.sv
hdl/hblt_dp.sv
hdl/node_heartbeat_liveness_table_core.sv
hdl/hblt_chk.sv
dv/tb.sv
